### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define DCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define DCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/dcr_pkg.sv
`default_nettype none

package dcr_pkg;

    // per-request control carried alongside the divider lanes
    typedef struct packed {
        logic mv1;
        logic mv2;
        logic neg_x;
        logic neg_y;
    } t_ctl;

endpackage

`default_nettype wire

### rtl/core/dcr_isqrt.sv
`default_nettype none

module dcr_isqrt #(
    parameter int RAD_W = 66,
    parameter int TAG_W = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire logic [RAD_W-1:0]   i_rad_a,
    input  wire logic [RAD_W-1:0]   i_rad_b,
    input  wire logic [TAG_W-1:0]   i_tag,
    output logic                    o_vld,
    output logic [RAD_W/2-1:0]      o_root_a,
    output logic [RAD_W/2-1:0]      o_root_b,
    output logic [TAG_W-1:0]        o_tag
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [RAD_W-1:0]  r_rad  [ROOT_W][2];
    logic [REM_W-1:0]  r_rem  [ROOT_W][2];
    logic [ROOT_W-1:0] r_root [ROOT_W][2];
    logic [TAG_W-1:0]  r_tag  [ROOT_W];
    logic              r_vld  [ROOT_W];
    logic [RAD_W-1:0]  w_rad_in [2];

    assign w_rad_in[0] = i_rad_a;
    assign w_rad_in[1] = i_rad_b;

    // one root bit per stage
    for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_st
        logic [TAG_W-1:0] w_tag;
        logic             w_vld;

        if (gi == 0) begin : g_first
            assign w_tag = i_tag;
            assign w_vld = i_vld;
        end else begin : g_next
            assign w_tag = r_tag[gi-1];
            assign w_vld = r_vld[gi-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi] <= 1'b0;
            end else if (i_en) begin
                r_vld[gi] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[gi] <= w_tag;
            end
        end

        for (genvar gl = 0; gl < 2; gl++) begin : g_ln
            logic [RAD_W-1:0]  w_rad;
            logic [REM_W-1:0]  w_rem;
            logic [ROOT_W-1:0] w_root;
            logic [REM_W+1:0]  w_sh;
            logic [REM_W+1:0]  w_trial;

            if (gi == 0) begin : g_first
                assign w_rad  = w_rad_in[gl];
                assign w_rem  = '0;
                assign w_root = '0;
            end else begin : g_next
                assign w_rad  = r_rad[gi-1][gl];
                assign w_rem  = r_rem[gi-1][gl];
                assign w_root = r_root[gi-1][gl];
            end

            assign w_sh    = {w_rem, w_rad[RAD_W-1 -: 2]};
            assign w_trial = {2'b00, w_root, 2'b01};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[gi][gl] <= w_rad << 2;
                    if (w_sh >= w_trial) begin
                        r_rem[gi][gl]  <= REM_W'(w_sh - w_trial);
                        r_root[gi][gl] <= {w_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem[gi][gl]  <= w_sh[REM_W-1:0];
                        r_root[gi][gl] <= {w_root[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_vld    = r_vld[ROOT_W-1];
    assign o_tag    = r_tag[ROOT_W-1];
    assign o_root_a = r_root[ROOT_W-1][0];
    assign o_root_b = r_root[ROOT_W-1][1];

endmodule

`default_nettype wire

### rtl/core/dcr_div.sv
`default_nettype none

module dcr_div import dcr_pkg::*; #(
    parameter int NUM_W = 66,
    parameter int DEN_W = 34,
    parameter int Q_W   = 33
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire logic [NUM_W-1:0]   i_num_x,
    input  wire logic [NUM_W-1:0]   i_num_y,
    input  wire logic [DEN_W-1:0]   i_den,
    input  wire t_ctl               i_ctl,
    output logic                    o_vld,
    output logic [Q_W-1:0]          o_quo_x,
    output logic [Q_W-1:0]          o_quo_y,
    output t_ctl                    o_ctl
);

    logic [DEN_W-1:0] r_rem [Q_W][2];
    logic [Q_W-1:0]   r_low [Q_W][2];
    logic [DEN_W-1:0] r_den [Q_W];
    t_ctl             r_ctl [Q_W];
    logic             r_vld [Q_W];
    logic [NUM_W-1:0] w_num [2];

    assign w_num[0] = i_num_x;
    assign w_num[1] = i_num_y;

    // restoring division, one quotient bit per stage
    for (genvar gi = 0; gi < Q_W; gi++) begin : g_st
        logic [DEN_W-1:0] w_den;
        t_ctl             w_ctl;
        logic             w_vld;

        if (gi == 0) begin : g_first
            assign w_den = i_den;
            assign w_ctl = i_ctl;
            assign w_vld = i_vld;
        end else begin : g_next
            assign w_den = r_den[gi-1];
            assign w_ctl = r_ctl[gi-1];
            assign w_vld = r_vld[gi-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi] <= 1'b0;
            end else if (i_en) begin
                r_vld[gi] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[gi] <= w_den;
                r_ctl[gi] <= w_ctl;
            end
        end

        for (genvar gl = 0; gl < 2; gl++) begin : g_ln
            logic [DEN_W-1:0] w_rem;
            logic [Q_W-1:0]   w_low;
            logic [DEN_W:0]   w_sh;

            if (gi == 0) begin : g_first
                assign w_rem = DEN_W'(w_num[gl] >> Q_W);
                assign w_low = w_num[gl][Q_W-1:0];
            end else begin : g_next
                assign w_rem = r_rem[gi-1][gl];
                assign w_low = r_low[gi-1][gl];
            end

            assign w_sh = {w_rem, w_low[Q_W-1]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_sh >= {1'b0, w_den}) begin
                        r_rem[gi][gl] <= DEN_W'(w_sh - {1'b0, w_den});
                        r_low[gi][gl] <= {w_low[Q_W-2:0], 1'b1};
                    end else begin
                        r_rem[gi][gl] <= w_sh[DEN_W-1:0];
                        r_low[gi][gl] <= {w_low[Q_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_vld   = r_vld[Q_W-1];
    assign o_ctl   = r_ctl[Q_W-1];
    assign o_quo_x = r_low[Q_W-1][0];
    assign o_quo_y = r_low[Q_W-1][1];

endmodule

`default_nettype wire

### rtl/core/distance_constraint_resolve.sv
// channel   direction  handshake            payload
// request   in         i_valid / o_stall    positions, pinned flags, rest length
// result    out        o_valid / i_stall    offsets for both points
//
// one request per cycle while o_stall is low
// latency is dominated by the bit-per-stage square root and divider pipelines
// synchronous active-low reset empties every stage
// a stalled result freezes the whole pipeline; o_stall rises only then
`default_nettype none
`include "assert_macros.svh"

module distance_constraint_resolve import dcr_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [COORD_WIDTH-1:0]    i_first_x,
    input  wire logic [COORD_WIDTH-1:0]    i_first_y,
    input  wire logic [COORD_WIDTH-1:0]    i_second_x,
    input  wire logic [COORD_WIDTH-1:0]    i_second_y,
    input  wire logic [COORD_WIDTH-1:0]    i_first_prev_x,
    input  wire logic [COORD_WIDTH-1:0]    i_first_prev_y,
    input  wire logic [COORD_WIDTH-1:0]    i_second_prev_x,
    input  wire logic [COORD_WIDTH-1:0]    i_second_prev_y,
    input  wire logic                      i_first_fixed,
    input  wire logic                      i_second_fixed,
    input  wire logic [COORD_WIDTH-2:0]    i_rest_length,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [COORD_WIDTH-1:0]         o_first_dx,
    output logic [COORD_WIDTH-1:0]         o_first_dy,
    output logic [COORD_WIDTH-1:0]         o_second_dx,
    output logic [COORD_WIDTH-1:0]         o_second_dy
);

    localparam int W      = COORD_WIDTH;
    localparam int DW     = W + 1;
    localparam int SQ_W   = 2 * W + 1;
    localparam int RAD_W  = 2 * W + 2;
    localparam int ROOT_W = W + 1;
    localparam int E_W    = W + 2;
    localparam int NUM_W  = 2 * W + 2;
    localparam int DEN_W  = W + 2;
    localparam int Q_W    = W + 1;
    localparam int TAG_W  = 4 * DW + (W - 1) + 4;

    function automatic logic [DW-1:0] mag_d(input logic [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : v;
    endfunction

    function automatic logic [W-1:0] sat(input logic [Q_W-1:0] q, input logic neg);
        logic signed [Q_W:0] s;
        logic signed [Q_W:0] s_max;
        logic signed [Q_W:0] s_min;
        s_max = $signed({2'b00, {(W-1){1'b1}}});
        s_min = $signed({2'b11, {(W-1){1'b0}}});
        s     = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (s > s_max) begin
            s = s_max;
        end else if (s < s_min) begin
            s = s_min;
        end
        return s[W-1:0];
    endfunction

    logic r_out_valid;
    logic w_en;

    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;

    // stage a: differences
    logic          r_a_vld;
    logic [DW-1:0] r_a_dx, r_a_dy, r_a_px, r_a_py;
    logic [W-2:0]  r_a_len;
    logic          r_a_pin1, r_a_pin2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_dx   <= {i_second_x[W-1], i_second_x} - {i_first_x[W-1], i_first_x};
            r_a_dy   <= {i_second_y[W-1], i_second_y} - {i_first_y[W-1], i_first_y};
            r_a_px   <= {i_second_prev_x[W-1], i_second_prev_x}
                        - {i_first_prev_x[W-1], i_first_prev_x};
            r_a_py   <= {i_second_prev_y[W-1], i_second_prev_y}
                        - {i_first_prev_y[W-1], i_first_prev_y};
            r_a_len  <= i_rest_length;
            r_a_pin1 <= i_first_fixed;
            r_a_pin2 <= i_second_fixed;
        end
    end

    // stage b: squares
    logic [DW-1:0]   w_m_dx, w_m_dy, w_m_px, w_m_py;
    logic [2*DW-1:0] w_p_dx, w_p_dy, w_p_px, w_p_py;

    assign w_m_dx = mag_d(r_a_dx);
    assign w_m_dy = mag_d(r_a_dy);
    assign w_m_px = mag_d(r_a_px);
    assign w_m_py = mag_d(r_a_py);
    assign w_p_dx = w_m_dx * w_m_dx;
    assign w_p_dy = w_m_dy * w_m_dy;
    assign w_p_px = w_m_px * w_m_px;
    assign w_p_py = w_m_py * w_m_py;

    logic            r_b_vld;
    logic [SQ_W-1:0] r_b_sdx, r_b_sdy, r_b_spx, r_b_spy;
    logic [DW-1:0]   r_b_dx, r_b_dy, r_b_px, r_b_py;
    logic [W-2:0]    r_b_len;
    logic            r_b_pin1, r_b_pin2, r_b_ccoin, r_b_pcoin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_sdx   <= w_p_dx[SQ_W-1:0];
            r_b_sdy   <= w_p_dy[SQ_W-1:0];
            r_b_spx   <= w_p_px[SQ_W-1:0];
            r_b_spy   <= w_p_py[SQ_W-1:0];
            r_b_dx    <= r_a_dx;
            r_b_dy    <= r_a_dy;
            r_b_px    <= r_a_px;
            r_b_py    <= r_a_py;
            r_b_len   <= r_a_len;
            r_b_pin1  <= r_a_pin1;
            r_b_pin2  <= r_a_pin2;
            r_b_ccoin <= (r_a_dx == '0) && (r_a_dy == '0);
            r_b_pcoin <= (r_a_px == '0) && (r_a_py == '0);
        end
    end

    // stage c: radicands
    logic             r_c_vld;
    logic [RAD_W-1:0] r_c_rad_c, r_c_rad_p;
    logic [TAG_W-1:0] r_c_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_rad_c <= {1'b0, r_b_sdx} + {1'b0, r_b_sdy};
            r_c_rad_p <= {1'b0, r_b_spx} + {1'b0, r_b_spy};
            r_c_tag   <= {r_b_dx, r_b_dy, r_b_px, r_b_py, r_b_len,
                          r_b_pin1, r_b_pin2, r_b_ccoin, r_b_pcoin};
        end
    end

    // square roots of both distances
    logic              w_s_vld;
    logic [ROOT_W-1:0] w_s_root_c, w_s_root_p;
    logic [TAG_W-1:0]  w_s_tag;

    dcr_isqrt #(
        .RAD_W (RAD_W),
        .TAG_W (TAG_W)
    ) u_isqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (r_c_vld),
        .i_rad_a  (r_c_rad_c),
        .i_rad_b  (r_c_rad_p),
        .i_tag    (r_c_tag),
        .o_vld    (w_s_vld),
        .o_root_a (w_s_root_c),
        .o_root_b (w_s_root_p),
        .o_tag    (w_s_tag)
    );

    logic [DW-1:0] w_s_dx, w_s_dy, w_s_px, w_s_py;
    logic [W-2:0]  w_s_len;
    logic          w_s_pin1, w_s_pin2, w_s_ccoin, w_s_pcoin;

    assign {w_s_dx, w_s_dy, w_s_px, w_s_py, w_s_len,
            w_s_pin1, w_s_pin2, w_s_ccoin, w_s_pcoin} = w_s_tag;

    // stage e: error and direction
    logic [DW-1:0]     n_e_vx, n_e_vy;
    logic [ROOT_W-1:0] n_e_vd;

    always_comb begin
        n_e_vx = w_s_dx;
        n_e_vy = w_s_dy;
        n_e_vd = w_s_root_c;
        if (w_s_ccoin) begin
            if (w_s_pcoin) begin
                n_e_vx = DW'(1);
                n_e_vy = '0;
                n_e_vd = ROOT_W'(1);
            end else begin
                n_e_vx = w_s_px;
                n_e_vy = w_s_py;
                n_e_vd = w_s_root_p;
            end
        end
    end

    logic              r_e_vld;
    logic [E_W-1:0]    r_e_err;
    logic [DW-1:0]     r_e_vx, r_e_vy;
    logic [ROOT_W-1:0] r_e_vd;
    logic              r_e_half, r_e_mv1, r_e_mv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= w_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_err  <= {1'b0, w_s_root_c} - {3'b000, w_s_len};
            r_e_vx   <= n_e_vx;
            r_e_vy   <= n_e_vy;
            r_e_vd   <= n_e_vd;
            r_e_half <= !w_s_pin1 && !w_s_pin2;
            r_e_mv1  <= w_s_pin2 || !w_s_pin1;
            r_e_mv2  <= !w_s_pin2;
        end
    end

    // stage m: numerators and divisor
    logic [E_W-1:0] w_e_mag_full;
    logic [DW-1:0]  w_e_mag;

    assign w_e_mag_full = r_e_err[E_W-1] ? E_W'(-r_e_err) : r_e_err;
    assign w_e_mag      = w_e_mag_full[DW-1:0];

    logic             r_m_vld;
    logic [NUM_W-1:0] r_m_num_x, r_m_num_y;
    logic [DEN_W-1:0] r_m_den;
    t_ctl             r_m_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_num_x     <= mag_d(r_e_vx) * w_e_mag;
            r_m_num_y     <= mag_d(r_e_vy) * w_e_mag;
            r_m_den       <= r_e_half ? {r_e_vd, 1'b0} : {1'b0, r_e_vd};
            r_m_ctl.mv1   <= r_e_mv1;
            r_m_ctl.mv2   <= r_e_mv2;
            r_m_ctl.neg_x <= r_e_vx[DW-1] ^ r_e_err[E_W-1];
            r_m_ctl.neg_y <= r_e_vy[DW-1] ^ r_e_err[E_W-1];
        end
    end

    logic           w_d_vld;
    logic [Q_W-1:0] w_d_qx, w_d_qy;
    t_ctl           w_d_ctl;

    dcr_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (Q_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_m_vld),
        .i_num_x (r_m_num_x),
        .i_num_y (r_m_num_y),
        .i_den   (r_m_den),
        .i_ctl   (r_m_ctl),
        .o_vld   (w_d_vld),
        .o_quo_x (w_d_qx),
        .o_quo_y (w_d_qy),
        .o_ctl   (w_d_ctl)
    );

    // output register with sign and saturation
    logic [W-1:0] r_out_fdx, r_out_fdy, r_out_sdx, r_out_sdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_fdx <= w_d_ctl.mv1 ? sat(w_d_qx, w_d_ctl.neg_x) : '0;
            r_out_fdy <= w_d_ctl.mv1 ? sat(w_d_qy, w_d_ctl.neg_y) : '0;
            r_out_sdx <= w_d_ctl.mv2 ? sat(w_d_qx, !w_d_ctl.neg_x) : '0;
            r_out_sdy <= w_d_ctl.mv2 ? sat(w_d_qy, !w_d_ctl.neg_y) : '0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_first_dx  = r_out_fdx;
    assign o_first_dy  = r_out_fdy;
    assign o_second_dx = r_out_sdx;
    assign o_second_dy = r_out_sdy;

    `DCR_ASSERT_ALWAYS(a_rst_empties, !i_rst_n |=> !o_valid, "reset left a result valid")
    `DCR_ASSERT(a_stall_needs_result, o_stall |-> o_valid, "stalled with no result held")
    `DCR_ASSERT(a_den_nonzero, r_m_vld |-> (r_m_den != '0), "zero divisor entered divider")
    `DCR_ASSERT(a_load_on_enable, $rose(o_valid) |-> $past(w_en), "result loaded while frozen")

endmodule

`default_nettype wire

### test/distance_constraint_resolve_tb.sv
`timescale 1ns / 1ps

module distance_constraint_resolve_tb;

    localparam int W = 32;
    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM = 1130;
    localparam int QUIET_FROM = 1000;
    localparam int PRESSURE_AT = 400;
    localparam int DRAIN_CYCLES = 2 * W + 30;

    typedef struct {
        logic [W-1:0] fx, fy, sx, sy, pfx, pfy, psx, psy;
        logic         pin1, pin2;
        logic [W-2:0] rest;
    } t_request;

    typedef struct {
        logic [W-1:0] d1x, d1y, d2x, d2y;
    } t_offsets;

    class offset_scoreboard;
        t_offsets pending[$];
        int errors = 0;
        int checked = 0;

        function automatic logic [63:0] isqrt(logic [127:0] n);
            logic [127:0] r, t;
            r = '0;
            for (int b = 40; b >= 0; b--) begin
                t = r | (128'd1 << b);
                if (t * t <= n) r = t;
            end
            return r[63:0];
        endfunction

        function automatic longint mag(longint x);
            return x < 0 ? -x : x;
        endfunction

        function automatic longint vlen(longint x, longint y);
            logic [127:0] mx, my;
            mx = 128'(mag(x));
            my = 128'(mag(y));
            return longint'(isqrt(mx * mx + my * my));
        endfunction

        function automatic longint scaled(longint v, longint e, logic [127:0] dv);
            logic [127:0] q;
            q = (128'(mag(v)) * 128'(mag(e))) / dv;
            return ((v < 0) != (e < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function automatic logic [W-1:0] sat(longint x);
            if (x > 64'sd2147483647) x = 64'sd2147483647;
            if (x < -64'sd2147483648) x = -64'sd2147483648;
            return x[W-1:0];
        endfunction

        function automatic void note(t_request r);
            longint dx, dy, vx, vy, d, vd, e, cx, cy, k, s1, s2;
            t_offsets o;
            dx = longint'($signed(r.sx)) - longint'($signed(r.fx));
            dy = longint'($signed(r.sy)) - longint'($signed(r.fy));
            d = vlen(dx, dy);
            e = d - longint'(r.rest);
            vx = dx; vy = dy; vd = d;
            if (dx == 0 && dy == 0) begin
                vx = longint'($signed(r.psx)) - longint'($signed(r.pfx));
                vy = longint'($signed(r.psy)) - longint'($signed(r.pfy));
                vd = vlen(vx, vy);
                if (vx == 0 && vy == 0) begin
                    vx = 1; vy = 0; vd = 1;
                end
            end
            if (r.pin2) begin
                k = 1; s1 = 1; s2 = 0;
            end else if (r.pin1) begin
                k = 1; s1 = 0; s2 = -1;
            end else begin
                k = 2; s1 = 1; s2 = -1;
            end
            cx = scaled(vx, e, 128'(vd * k));
            cy = scaled(vy, e, 128'(vd * k));
            o.d1x = sat(s1 * cx);
            o.d1y = sat(s1 * cy);
            o.d2x = sat(s2 * cx);
            o.d2y = sat(s2 * cy);
            pending.push_back(o);
        endfunction

        task report(string what, logic [W-1:0] got, logic [W-1:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check(t_offsets got);
            t_offsets want;
            if (pending.size() == 0) begin
                $display("unexpected result at %0t", $time);
                errors++;
            end else begin
                want = pending.pop_front();
                checked++;
                if (got.d1x !== want.d1x) report("first_dx", got.d1x, want.d1x);
                if (got.d1y !== want.d1y) report("first_dy", got.d1y, want.d1y);
                if (got.d2x !== want.d2x) report("second_dx", got.d2x, want.d2x);
                if (got.d2y !== want.d2y) report("second_dy", got.d2y, want.d2y);
            end
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         i_stall = 1'b0;
    logic [W-1:0] i_first_x = '0, i_first_y = '0, i_second_x = '0, i_second_y = '0;
    logic [W-1:0] i_first_prev_x = '0, i_first_prev_y = '0;
    logic [W-1:0] i_second_prev_x = '0, i_second_prev_y = '0;
    logic         i_first_fixed = 1'b0, i_second_fixed = 1'b0;
    logic [W-2:0] i_rest_length = '0;
    logic         o_stall, o_valid;
    logic [W-1:0] o_first_dx, o_first_dy, o_second_dx, o_second_dy;

    distance_constraint_resolve #(.COORD_WIDTH(W)) u_dut (.*);

    offset_scoreboard board = new();
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int sent = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("distance_constraint_resolve_tb: errors");
        $finish;
    end

    // result side with random stall bursts and one long hold-off
    initial begin
        int left;
        t_offsets got;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.d1x = o_first_dx;
                got.d1y = o_first_dy;
                got.d2x = o_second_dx;
                got.d2y = o_second_dy;
                board.check(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                left = 500;
            end else if (left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
                left = $urandom_range(1, 16);
            end
            if (left > 0) begin
                left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task send(t_request r);
        i_valid <= 1'b1;
        i_first_x <= r.fx;
        i_first_y <= r.fy;
        i_second_x <= r.sx;
        i_second_y <= r.sy;
        i_first_prev_x <= r.pfx;
        i_first_prev_y <= r.pfy;
        i_second_prev_x <= r.psx;
        i_second_prev_y <= r.psy;
        i_first_fixed <= r.pin1;
        i_second_fixed <= r.pin2;
        i_rest_length <= r.rest;
        do @(posedge i_clk); while (o_stall);
        board.note(r);
        sent++;
        if (sent == PRESSURE_AT) hold_req = 1'b1;
        if (sent >= QUIET_FROM) quiet = 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    function automatic logic [W-1:0] near(logic [W-1:0] c);
        return c + W'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
    endfunction

    function automatic t_request random_request();
        t_request r;
        int mode;
        mode = $urandom_range(0, 9);
        r.pin1 = 1'($urandom_range(0, 1));
        r.pin2 = 1'($urandom_range(0, 1));
        r.rest = ($urandom_range(0, 1) == 0) ? (W-1)'($urandom)
                                             : (W-1)'($urandom_range(0, 3 << 20));
        if (mode < 2) begin
            r.fx = $urandom; r.fy = $urandom; r.sx = $urandom; r.sy = $urandom;
            r.pfx = $urandom; r.pfy = $urandom; r.psx = $urandom; r.psy = $urandom;
        end else begin
            r.fx = $urandom >> $urandom_range(0, 12);
            r.fy = $urandom >> $urandom_range(0, 12);
            r.sx = near(r.fx);
            r.sy = near(r.fy);
            r.pfx = near(r.fx);
            r.pfy = near(r.fy);
            r.psx = near(r.sx);
            r.psy = near(r.sy);
            if (mode == 2 || mode == 3) begin
                r.sx = r.fx; r.sy = r.fy;
            end
            if (mode == 3) begin
                r.psx = r.pfx; r.psy = r.pfy;
            end
        end
        return r;
    endfunction

    function automatic t_request directed_request(int n);
        t_request r;
        logic [W-1:0] mn, mx;
        mn = {1'b1, {(W-1){1'b0}}};
        mx = {1'b0, {(W-1){1'b1}}};
        r = '{fx: '0, fy: '0, sx: 32'h0003_0000, sy: 32'h0004_0000, pfx: '0, pfy: '0,
              psx: '0, psy: '0, pin1: n[0], pin2: n[1], rest: 31'h0001_0000};
        case (n / 4)
            0: ;
            1: begin
                r.fx = mn; r.fy = mn; r.sx = mx; r.sy = mx; r.rest = '0;
            end
            2: begin
                r.fx = mx; r.fy = mn; r.sx = mn; r.sy = mx; r.rest = '1;
            end
            3: begin
                r.sx = r.fx; r.sy = r.fy; r.psx = 32'hfffe_0000; r.psy = 32'h0002_0000;
            end
            default: begin
                r.sx = r.fx; r.sy = r.fy; r.rest = '1;
            end
        endcase
        return r;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int n = 0; n < N_DIRECTED; n++) send(directed_request(n));
        for (int n = 0; n < N_RANDOM; n++) send(random_request());
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d requests, %0d results compared", sent, board.checked);
        $display("covered pinned combinations, coincident points and saturation");
        if (board.errors == 0) begin
            $display("distance_constraint_resolve_tb: clean");
        end else begin
            $display("distance_constraint_resolve_tb: errors");
        end
        $finish;
    end

endmodule
